// ===== src/rpcf_pkg.sv =====
// Shared types, mode codes and fixed-point constants for the RGB point color filter.
package rpcf_pkg;

    typedef enum logic [3:0] {
        MODE_PASS       = 4'd0,
        MODE_YELLOW     = 4'd1,
        MODE_BLUE_ONLY  = 4'd2,
        MODE_BLUE_GRAY  = 4'd3,
        MODE_BRIGHTNESS = 4'd4,
        MODE_CYAN       = 4'd5,
        MODE_MEAN_GRAY  = 4'd6,
        MODE_GREEN_GRAY = 4'd7,
        MODE_INVERT     = 4'd8,
        MODE_LUMINANCE  = 4'd9,
        MODE_MAGENTA    = 4'd10,
        MODE_RED_GRAY   = 4'd11,
        MODE_SEPIA      = 4'd12,
        MODE_THRESHOLD  = 4'd13,
        MODE_GREEN_ONLY = 4'd14,
        MODE_RED_ONLY   = 4'd15
    } mode_t;

    localparam logic [1:0] CFG_FILTER_MODE     = 2'd0;
    localparam logic [1:0] CFG_THRESHOLD_LEVEL = 2'd1;

    localparam logic [3:0] FILTER_MODE_RESET     = 4'd0;
    localparam logic [7:0] THRESHOLD_LEVEL_RESET = 8'd200;

    // Q16 weights
    localparam logic [15:0] LUM_WR = 16'd13926;
    localparam logic [15:0] LUM_WG = 16'd46885;
    localparam logic [15:0] LUM_WB = 16'd4725;
    localparam logic [15:0] SEP_WR = 16'd19661;
    localparam logic [15:0] SEP_WG = 16'd38666;
    localparam logic [15:0] SEP_WB = 16'd7209;

    // x / 3 == (x * 683) >> 11 for x <= 765
    localparam logic [19:0] MEAN_RECIP = 20'd683;
    localparam int          MEAN_SHIFT = 11;

    localparam logic [7:0] CH_MAX      = 8'd255;
    localparam logic [8:0] SEPIA_R_ADD = 9'd40;
    localparam logic [8:0] SEPIA_G_ADD = 9'd20;
    localparam logic [7:0] SEPIA_B_SUB = 8'd20;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct packed {
        mode_t      mode;
        rgb_t       pix;
        logic [23:0] prod_r;
        logic [23:0] prod_g;
        logic [23:0] prod_b;
        logic [7:0] bright;
        logic [9:0] sum3;
        logic       above;
    } front_t;

    typedef struct packed {
        mode_t      mode;
        rgb_t       pix;
        logic [7:0] weighted;
        logic [7:0] mean;
        logic [7:0] bright;
        logic       above;
    } mid_t;

endpackage

// ===== src/rpcf_front.sv =====
// First pipeline stage: weight products, brightness, channel sum and threshold compare.
module rpcf_front
    import rpcf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  mode_t      mode,
    input  logic [7:0] level,
    input  logic       in_valid,
    output logic       in_ready,
    input  rgb_t       in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output front_t     out_data
);

    logic       valid_reg;
    front_t     data_reg;
    front_t     data_next;
    logic [15:0] wr;
    logic [15:0] wg;
    logic [15:0] wb;
    logic [7:0] max_rg;
    logic [7:0] max_rgb;
    logic [7:0] min_gb;
    logic [7:0] half_min;
    logic [7:0] min_term;

    always_comb
    begin
        if (mode == MODE_SEPIA)
        begin
            wr = SEP_WR;
            wg = SEP_WG;
            wb = SEP_WB;
        end
        else
        begin
            wr = LUM_WR;
            wg = LUM_WG;
            wb = LUM_WB;
        end
    end

    always_comb
    begin
        max_rg   = (in_data.red > in_data.green) ? in_data.red : in_data.green;
        max_rgb  = (max_rg > in_data.blue) ? max_rg : in_data.blue;
        min_gb   = (in_data.green < in_data.blue) ? in_data.green : in_data.blue;
        half_min = min_gb >> 1;
        min_term = (in_data.red < half_min) ? in_data.red : half_min;
    end

    always_comb
    begin
        data_next.mode   = mode;
        data_next.pix    = in_data;
        data_next.prod_r = {16'd0, in_data.red} * {8'd0, wr};
        data_next.prod_g = {16'd0, in_data.green} * {8'd0, wg};
        data_next.prod_b = {16'd0, in_data.blue} * {8'd0, wb};
        data_next.bright = max_rgb + min_term;
        data_next.sum3   = {2'd0, in_data.red} + {2'd0, in_data.green}
                           + {2'd0, in_data.blue};
        data_next.above  = (in_data.red > level);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== src/rpcf_mid.sv =====
// Second pipeline stage: weighted gray from the products and mean gray by reciprocal multiply.
module rpcf_mid
    import rpcf_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  front_t in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output mid_t   out_data
);

    logic        valid_reg;
    mid_t        data_reg;
    mid_t        data_next;
    logic [25:0] wsum;
    logic [19:0] mean_prod;

    always_comb
    begin
        wsum      = {2'd0, in_data.prod_r} + {2'd0, in_data.prod_g}
                    + {2'd0, in_data.prod_b};
        mean_prod = {10'd0, in_data.sum3} * MEAN_RECIP;

        data_next.mode     = in_data.mode;
        data_next.pix      = in_data.pix;
        data_next.weighted = wsum[23:16];
        data_next.mean     = mean_prod[MEAN_SHIFT +: 8];
        data_next.bright   = in_data.bright;
        data_next.above    = in_data.above;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== src/rpcf_back.sv =====
// Third pipeline stage: per-mode output selection, sepia clamping and the output register.
module rpcf_back
    import rpcf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  mid_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output rgb_t out_data
);

    logic       valid_reg;
    rgb_t       data_reg;
    rgb_t       data_next;
    logic [8:0] sep_r;
    logic [8:0] sep_g;
    logic [7:0] sep_b;
    logic [7:0] thr;
    rgb_t       p;

    always_comb
    begin
        p     = in_data.pix;
        sep_r = {1'b0, in_data.weighted} + SEPIA_R_ADD;
        sep_g = {1'b0, in_data.weighted} + SEPIA_G_ADD;
        sep_b = (in_data.weighted > SEPIA_B_SUB) ? (in_data.weighted - SEPIA_B_SUB) : 8'd0;
        thr   = in_data.above ? CH_MAX : 8'd0;
    end

    always_comb
    begin
        data_next = p;
        unique case (in_data.mode)
            MODE_PASS:       data_next = p;
            MODE_YELLOW:     data_next = '{CH_MAX, CH_MAX, 8'd0};
            MODE_BLUE_ONLY:  data_next = '{8'd0, 8'd0, p.blue};
            MODE_BLUE_GRAY:  data_next = '{p.blue, p.blue, p.blue};
            MODE_BRIGHTNESS: data_next = '{in_data.bright, in_data.bright, in_data.bright};
            MODE_CYAN:       data_next = '{8'd0, CH_MAX, CH_MAX};
            MODE_MEAN_GRAY:  data_next = '{in_data.mean, in_data.mean, in_data.mean};
            MODE_GREEN_GRAY: data_next = '{p.green, p.green, p.green};
            MODE_INVERT:     data_next = '{~p.red, ~p.green, ~p.blue};
            MODE_LUMINANCE:
                data_next = '{in_data.weighted, in_data.weighted, in_data.weighted};
            MODE_MAGENTA:    data_next = '{CH_MAX, 8'd0, CH_MAX};
            MODE_RED_GRAY:   data_next = '{p.red, p.red, p.red};
            MODE_SEPIA:
            begin
                data_next.red   = sep_r[8] ? CH_MAX : sep_r[7:0];
                data_next.green = sep_g[8] ? CH_MAX : sep_g[7:0];
                data_next.blue  = sep_b;
            end
            MODE_THRESHOLD:  data_next = '{thr, thr, thr};
            MODE_GREEN_ONLY: data_next = '{8'd0, p.green, 8'd0};
            MODE_RED_ONLY:   data_next = '{p.red, 8'd0, 8'd0};
            default:         data_next = p;
        endcase
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    // sepia output is ordered red >= green >= blue
    a_sepia_order: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_data.mode == MODE_SEPIA)
        |=> (data_reg.red >= data_reg.green && data_reg.green >= data_reg.blue))
        else $error("sepia channel order broken");

    a_threshold_bw: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_data.mode == MODE_THRESHOLD)
        |=> (data_reg.red == data_reg.green && data_reg.green == data_reg.blue
             && (data_reg.red == 8'd0 || data_reg.red == CH_MAX)))
        else $error("threshold output not black or white");

    a_invert: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_data.mode == MODE_INVERT)
        |=> (data_reg.red == ~$past(in_data.pix.red)
             && data_reg.blue == ~$past(in_data.pix.blue)))
        else $error("invert result mismatch");

endmodule

// ===== src/rgb_point_color_filter.sv =====
// Top level of the RGB point color filter: configuration registers and three-stage pipeline.
//
// Usage:
//   Input channel in_valid/in_ready carries one pixel (red_in, green_in, blue_in)
//   per transaction; output channel out_valid/out_ready returns the recolored
//   pixel (red_out, green_out, blue_out), one result per input, in order.
//   cfg_we/cfg_index/cfg_data write filter_mode (index 0, 4 bits) or
//   threshold_level (index 1, 8 bits); other indexes are ignored. Write only
//   while no transaction is in flight.
//   Pipeline: three register stages (product stage, sum/reciprocal stage,
//   select/output register); an accepted pixel passes through the front, mid
//   and back registers in that order before out_valid rises. Throughput: one
//   pixel per cycle while out_ready is high; each stage holds one transaction.
//   Reset: pipeline empties, filter_mode goes to pass-through, threshold_level
//   to 200.
//   Receiver stall: each stage holds its transaction while the next is full and
//   stalled; in_ready drops once all three stages are occupied, and nothing is
//   dropped or repeated.
module rgb_point_color_filter
    import rpcf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] red_in,
    input  logic [7:0] green_in,
    input  logic [7:0] blue_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] red_out,
    output logic [7:0] green_out,
    output logic [7:0] blue_out,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    mode_t      filter_mode_reg;
    logic [7:0] threshold_level_reg;

    rgb_t   in_pix;
    rgb_t   out_pix;
    front_t front_data;
    mid_t   mid_data;
    logic   front_valid;
    logic   front_ready;
    logic   mid_valid;
    logic   mid_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_mode_reg     <= mode_t'(FILTER_MODE_RESET);
            threshold_level_reg <= THRESHOLD_LEVEL_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_FILTER_MODE)
            begin
                filter_mode_reg <= mode_t'(cfg_data[3:0]);
            end
            if (cfg_index == CFG_THRESHOLD_LEVEL)
            begin
                threshold_level_reg <= cfg_data;
            end
        end
    end

    assign in_pix = '{red_in, green_in, blue_in};

    rpcf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (filter_mode_reg),
        .level     (threshold_level_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_pix),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_data  (front_data)
    );

    rpcf_mid u_mid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .out_data  (mid_data)
    );

    rpcf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .in_data   (mid_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_pix)
    );

    assign red_out   = out_pix.red;
    assign green_out = out_pix.green;
    assign blue_out  = out_pix.blue;

endmodule
